// ----- src/oaids_pkg.sv -----
// shared types, codes and field widths for the ordered array block
// no dependencies; imported by oaids_seq and the top level module in src

package oaids_pkg;

    // default sizing handed down from the top level
    localparam int DEF_CAPACITY   = 32;
    localparam int DEF_DATA_WIDTH = 32;

    // fixed field widths of the stream beats
    localparam int OP_W      = 2;
    localparam int POS_W     = 6;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int FIDX_W    = 5;
    localparam int COUNT_W   = 6;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_SEARCH
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_BAD_POS,
        STAT_FULL,
        STAT_MISS
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [FIDX_W-1:0]   found_index;
        logic [COUNT_W-1:0]  count;
    } res_t;

endpackage

// ----- src/oaids_ram.sv -----
// single-port-write, single-port-read entry store with registered read data
// no package dependency

module oaids_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/oaids_seq.sv -----
// sequencer: checks each request, walks the store for shifts and searches,
// keeps the live count; depends on oaids_pkg and drives oaids_ram

module oaids_seq #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [oaids_pkg::OP_W-1:0]  in_op,
    input  logic [oaids_pkg::POS_W-1:0] in_pos,
    input  logic [DATA_WIDTH-1:0]       in_word,
    output logic                        res_valid,
    input  logic                        res_ready,
    output oaids_pkg::res_t             res,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [DATA_WIDTH-1:0]       wr_data,
    output logic                        rd_en,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [DATA_WIDTH-1:0]       rd_data
);

    import oaids_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         last_reg, last_next;
    logic [AW-1:0]         wa_reg, wa_next;
    logic                  reading_reg, reading_next;
    logic                  pend_reg, pend_next;
    res_t                  res_reg, res_next;

    op_t           op_in;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] cnt_x;
    logic          accept;
    logic          ins_bad;
    logic          ins_full;
    logic          del_bad;
    logic          go_shift;
    logic          go_search;
    logic          shift_fin;
    logic          hit;
    logic          miss;
    logic          going_up;

    assign op_in     = op_t'(in_op);
    assign pos_x     = PW'(in_pos);
    assign cnt_x     = PW'(count_reg);
    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign ins_bad   = pos_x > cnt_x;
    assign ins_full  = cnt_x == PW'(CAPACITY);
    assign del_bad   = pos_x >= cnt_x;
    assign go_shift  = accept && (((op_in == OP_INSERT) && !ins_bad && !ins_full)
                                  || ((op_in == OP_DELETE) && !del_bad));
    assign go_search = accept && (op_in == OP_SEARCH) && (count_reg != '0);
    assign shift_fin = (state_reg == ST_SHIFT) && !reading_reg && !pend_reg;
    assign hit       = (state_reg == ST_SEARCH) && pend_reg && (rd_data == word_reg);
    assign miss      = (state_reg == ST_SEARCH) && !reading_reg && !pend_reg;
    assign going_up  = op_reg == OP_INSERT;

    assign in_ready  = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res       = res_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (go_shift) begin
                    state_next = ST_SHIFT;
                end else if (go_search) begin
                    state_next = ST_SEARCH;
                end else if (accept) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (shift_fin) begin
                    state_next = ST_DONE;
                end
            end
            ST_SEARCH: begin
                if (hit || miss) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        op_next      = op_reg;
        pos_next     = pos_reg;
        word_next    = word_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        last_next    = last_reg;
        wa_next      = wa_reg;
        reading_next = reading_reg;
        pend_next    = 1'b0;
        res_next     = res_reg;
        rd_en        = 1'b0;
        rd_addr      = ptr_reg;
        wr_en        = 1'b0;
        wr_addr      = wa_reg;
        wr_data      = rd_data;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next      = op_in;
                    pos_next     = AW'(in_pos);
                    word_next    = in_word;
                    reading_next = 1'b0;
                    res_next.found_index = '0;
                    res_next.count       = COUNT_W'(count_reg);
                    res_next.status      = STAT_OK;
                    case (op_in)
                        OP_INSERT: begin
                            // walk down from the top live entry to the slot
                            ptr_next     = AW'(count_reg - CW'(1));
                            last_next    = AW'(in_pos);
                            reading_next = pos_x != cnt_x;
                            if (ins_bad) begin
                                res_next.status = STAT_BAD_POS;
                            end else if (ins_full) begin
                                res_next.status = STAT_FULL;
                            end
                        end
                        OP_DELETE: begin
                            // walk up from the slot above the removed one
                            ptr_next     = AW'(in_pos) + AW'(1);
                            last_next    = AW'(count_reg - CW'(1));
                            reading_next = (pos_x + PW'(1)) != cnt_x;
                            if (del_bad) begin
                                res_next.status = STAT_BAD_POS;
                            end
                        end
                        OP_SEARCH: begin
                            ptr_next     = '0;
                            last_next    = AW'(count_reg - CW'(1));
                            reading_next = count_reg != '0;
                            if (count_reg == '0) begin
                                res_next.status = STAT_MISS;
                            end
                        end
                        default: begin
                            res_next.status = STAT_BAD_POS;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                rd_en     = reading_reg;
                pend_next = reading_reg;
                if (reading_reg) begin
                    wa_next = going_up ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                    if (ptr_reg == last_reg) begin
                        reading_next = 1'b0;
                    end else begin
                        ptr_next = going_up ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                    end
                end
                if (pend_reg) begin
                    wr_en = 1'b1;
                end else if (!reading_reg) begin
                    if (going_up) begin
                        wr_en      = 1'b1;
                        wr_addr    = pos_reg;
                        wr_data    = word_reg;
                        count_next = count_reg + CW'(1);
                    end else begin
                        count_next = count_reg - CW'(1);
                    end
                    res_next.status      = STAT_OK;
                    res_next.found_index = '0;
                    res_next.count       = COUNT_W'(count_next);
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    res_next.status      = STAT_OK;
                    res_next.found_index = FIDX_W'(wa_reg);
                    res_next.count       = COUNT_W'(count_reg);
                end else if (miss) begin
                    res_next.status      = STAT_MISS;
                    res_next.found_index = '0;
                    res_next.count       = COUNT_W'(count_reg);
                end else begin
                    rd_en     = reading_reg;
                    pend_next = reading_reg;
                    if (reading_reg) begin
                        wa_next = ptr_reg;
                        if (ptr_reg == last_reg) begin
                            reading_next = 1'b0;
                        end else begin
                            ptr_next = ptr_reg + AW'(1);
                        end
                    end
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            reading_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            reading_reg <= reading_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        pos_reg  <= pos_next;
        word_reg <= word_next;
        ptr_reg  <= ptr_next;
        last_reg <= last_next;
        wa_reg   <= wa_next;
        res_reg  <= res_next;
    end

endmodule

// ----- src/ordered_array_insert_delete_search.sv -----
// top level of the ordered array block: stream ports, field packing, output stage
// depends on oaids_pkg, oaids_seq and oaids_ram
//
// usage
//   s_ channel: one request beat = operation, position and value; every request
//   gives exactly one result beat on the m_ channel (status, found index, count)
//   the list lives in a synchronous memory with registered read data; insert and
//   delete move the entries above the position one slot per cycle, search reads
//   one entry a cycle; a rejected request or a search of an empty list goes
//   straight to its result without touching the store
//   one request is worked on at a time; s_tready rises again once the result has
//   gone into the output register
//   the output register holds a finished result while m_tready is low, so the
//   next request is taken and worked on meanwhile; it then waits for the slot
//   reset (aresetn low, synchronous) empties the list and drops both valids; the
//   store itself is not cleared, as only entries below the count are ever read

module ordered_array_insert_delete_search #(
    parameter int CAPACITY   = oaids_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = oaids_pkg::DEF_DATA_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request beat
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] operation, [7:2] position, [39:8] value
    input  logic [oaids_pkg::S_TDATA_W-1:0]     s_tdata,
    // result beat
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [6:2] found_index, [12:7] count, [15:13] zero
    output logic [oaids_pkg::M_TDATA_W-1:0]     m_tdata
);

    import oaids_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    // unpacked request fields
    logic [OP_W-1:0]         s_operation;
    logic [POS_W-1:0]        s_position;
    logic signed [VALUE_W-1:0] s_value;
    logic [DATA_WIDTH-1:0]   s_word;

    // sequencer result handshake
    logic res_valid;
    logic res_ready;
    res_t res;

    // store access
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign s_operation = s_tdata[1:0];
    assign s_position  = s_tdata[7:2];
    assign s_value     = s_tdata[39:8];
    // sign-extend or trim the value to the stored word width
    assign s_word      = DATA_WIDTH'(s_value);

    oaids_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_operation),
        .in_pos    (s_position),
        .in_word   (s_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    oaids_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // the output slot is free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, res.count, res.found_index, res.status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // one request at a time: no new beat right after one was taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one still in progress");

    // a finished result blocks new requests until it reaches the output stage
    a_no_take_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("request ready while a result is pending");

    // only a successful search carries a non-zero index
    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.status != STAT_OK) |-> (res.found_index == '0))
        else $error("non-zero index on a failed operation");

    // a handed-over result shows up on the result channel next cycle
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_tvalid)
        else $error("result lost between sequencer and output stage");

endmodule

// ----- sim/tb_ordered_array_insert_delete_search.sv -----
// self-checking bench for the ordered array block: directed table, then random traffic
// depends on oaids_pkg and ordered_array_insert_delete_search from src

module tb_ordered_array_insert_delete_search;
    timeunit 1ns;
    timeprecision 1ps;

    import oaids_pkg::*;

    localparam int          CAPACITY    = oaids_pkg::DEF_CAPACITY;
    localparam int          CYCLE_LIMIT = 400_000;
    localparam int          IDLE_MAX    = 12;
    localparam int          BLOCK_BEATS = 80;
    localparam int          BLOCKS      = 18;
    // the fourth opcode has no name in the package; the block must answer it with a bad status
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    // one row of the directed table; want is only used when typed is set
    typedef struct {
        logic [1:0]  op;
        logic [5:0]  pos;
        logic [31:0] word;
        bit          typed;
        res_t        want;
    } plan_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // [1:0] operation, [7:2] position, [39:8] value
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // [1:0] status, [6:2] found_index, [12:7] count, [15:13] zero
    logic [M_TDATA_W-1:0]   m_tdata;

    // our own copy of the list, updated as each request beat is taken
    logic [31:0]            list_words [CAPACITY];
    int                     list_len;
    res_t                   pending_results [$];
    plan_row_t              plan [$];
    int                     errors;
    int                     cycle_count;
    int                     results_seen;
    bit                     sender_calm;

    ordered_array_insert_delete_search u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // watchdog, reckoned from the slowest legal run several times over
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_ordered_array_insert_delete_search failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        errors++;
    endtask

    // what the list does with one request; updates the list copy and returns the result beat
    function automatic res_t apply_list_op(input logic [1:0] op, input logic [5:0] pos,
                                           input logic [31:0] word);
        res_t r;
        int   k;
        bit   hit;
        r.status      = STAT_OK;
        r.found_index = '0;
        hit           = 1'b0;
        case (op)
            OP_INSERT: begin
                // position check wins over the full check
                if (int'(pos) > list_len) begin
                    r.status = STAT_BAD_POS;
                end else if (list_len >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    for (k = list_len; k > int'(pos); k--)
                        list_words[k] = list_words[k-1];
                    list_words[pos] = word;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (int'(pos) >= list_len) begin
                    r.status = STAT_BAD_POS;
                end else begin
                    for (k = int'(pos); k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
            OP_SEARCH: begin
                r.status = STAT_MISS;
                for (k = 0; k < list_len && !hit; k++) begin
                    if (list_words[k] == word) begin
                        hit           = 1'b1;
                        r.status      = STAT_OK;
                        r.found_index = k[FIDX_W-1:0];
                    end
                end
            end
            default: r.status = STAT_BAD_POS;
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    // a word biased towards repeats and the extremes, so searches hit and duplicates occur
    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return 32'($urandom_range(0, 7));
        if (roll < 6) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [5:0] pos, input logic [31:0] word,
                           input bit typed = 1'b0, input status_t st = STAT_OK,
                           input int fidx = 0, input int cnt = 0);
        plan_row_t row;
        row.op                = op;
        row.pos               = pos;
        row.word              = word;
        row.typed             = typed;
        row.want.status       = st;
        row.want.found_index  = fidx[FIDX_W-1:0];
        row.want.count        = cnt[COUNT_W-1:0];
        plan.push_back(row);
    endtask

    // one request beat: optional gap, hold valid until taken, then predict
    task automatic send_beat(input logic [1:0] op, input logic [5:0] pos,
                             input logic [31:0] word, input bit typed, input res_t typed_want);
        int   gap;
        res_t predicted;
        gap = sender_calm ? 0 : $urandom_range(0, IDLE_MAX);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {word, pos, op};
        do @(posedge aclk); while (!s_tready);
        // the list copy is always advanced, even when the row carries its own answer
        predicted = apply_list_op(op, pos, word);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    // result side: a drawn stall before each beat, with calm stretches that never stall
    initial begin
        int stall;
        bit calm;
        m_tready = 1'b0;
        calm     = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, IDLE_MAX);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (results_seen % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
        end
    end

    // checker: every taken result beat against the oldest pending prediction
    initial results_seen = 0;
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat 0x%04h with nothing pending", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] != want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_tdata[1:0], want.status));
                if (m_tdata[6:2] != want.found_index)
                    report_mismatch($sformatf("found_index got %0d want %0d",
                                              m_tdata[6:2], want.found_index));
                if (m_tdata[12:7] != want.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              m_tdata[12:7], want.count));
            end
        end
    end

    // stimulus
    initial begin
        int         blk;
        int         n;
        int         roll;
        int         flavour;
        logic [1:0] op;
        logic [5:0] pos;
        logic [31:0] word;
        res_t       no_want;

        errors      = 0;
        list_len    = 0;
        sender_calm = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        no_want     = '{STAT_OK, '0, '0};

        // directed table; answers typed in only where they are plain to see
        add_row(OP_SEARCH, 6'd0,  32'h0000_0000, 1, STAT_MISS,    0, 0); // search on empty list
        add_row(OP_DELETE, 6'd0,  32'h0000_0000, 1, STAT_BAD_POS, 0, 0); // delete on empty list
        add_row(OP_INSERT, 6'd1,  32'h1234_5678, 1, STAT_BAD_POS, 0, 0); // insert past the end
        add_row(OP_INSERT, 6'd63, 32'h7fff_ffff, 1, STAT_BAD_POS, 0, 0); // top position
        add_row(OP_UNUSED, 6'd0,  32'h0000_0000, 1, STAT_BAD_POS, 0, 0); // unknown opcode
        add_row(OP_INSERT, 6'd0,  32'h8000_0000, 1, STAT_OK,      0, 1); // most negative word
        add_row(OP_INSERT, 6'd1,  32'h7fff_ffff, 1, STAT_OK,      0, 2); // most positive word
        add_row(OP_INSERT, 6'd0,  32'hffff_ffff);                        // insert at the front
        add_row(OP_INSERT, 6'd3,  32'h0000_0000);                        // append at the end
        add_row(OP_INSERT, 6'd2,  32'h7fff_ffff);                        // duplicate in the middle
        add_row(OP_SEARCH, 6'd63, 32'h7fff_ffff);                        // first of two copies
        add_row(OP_SEARCH, 6'd0,  32'h8000_0000);
        add_row(OP_SEARCH, 6'd5,  32'h0000_0000);                        // last live entry
        add_row(OP_SEARCH, 6'd0,  32'h1234_5678);                        // miss on a full-ish list
        add_row(OP_DELETE, 6'd5,  32'h0000_0000);                        // delete at the count
        add_row(OP_DELETE, 6'd63, 32'hffff_ffff);
        add_row(OP_UNUSED, 6'd63, 32'hffff_ffff);                        // unknown op, all ones
        add_row(OP_DELETE, 6'd0,  32'h0000_0000);                        // delete the front
        add_row(OP_DELETE, 6'd3,  32'h0000_0000);                        // delete the last
        add_row(OP_SEARCH, 6'd0,  32'hffff_ffff);                        // deleted word is gone
        add_row(OP_INSERT, 6'd3,  32'ha5a5_a5a5);
        add_row(OP_DELETE, 6'd1,  32'h0000_0000);                        // delete from the middle
        add_row(OP_SEARCH, 6'd0,  32'ha5a5_a5a5);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i])
            send_beat(plan[i].op, plan[i].pos, plan[i].word, plan[i].typed, plan[i].want);

        // random part in blocks: fill towards full, mix at a high count, drain towards empty
        for (blk = 0; blk < BLOCKS; blk++) begin
            flavour     = blk % 3;
            sender_calm = ($urandom_range(0, 2) == 0);
            for (n = 0; n < BLOCK_BEATS; n++) begin
                roll = $urandom_range(0, 99);
                case (flavour)
                    0:       op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_DELETE :
                                  (roll < 97) ? OP_SEARCH : OP_UNUSED;
                    1:       op = (roll < 40) ? OP_INSERT : (roll < 70) ? OP_DELETE :
                                  (roll < 97) ? OP_SEARCH : OP_UNUSED;
                    default: op = (roll < 12) ? OP_INSERT : (roll < 72) ? OP_DELETE :
                                  (roll < 97) ? OP_SEARCH : OP_UNUSED;
                endcase
                word = pick_word();
                pos  = 6'($urandom_range(0, 63));
                // mostly sound positions, the rest anywhere in the field
                if (op == OP_INSERT && $urandom_range(0, 99) < 85)
                    pos = 6'($urandom_range(0, list_len));
                else if (op == OP_DELETE && list_len > 0 && $urandom_range(0, 99) < 85)
                    pos = 6'($urandom_range(0, list_len - 1));
                // searches mostly look for a word that is on the list
                if (op == OP_SEARCH && list_len > 0 && $urandom_range(0, 99) < 60)
                    word = list_words[$urandom_range(0, list_len - 1)];
                send_beat(op, pos, word, 1'b0, no_want);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain, then allow a full worst-case latency for any stray beat
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (CAPACITY + 8) @(posedge aclk);

        if (errors == 0) begin
            $display("tb_ordered_array_insert_delete_search passed");
        end else begin
            $display("tb_ordered_array_insert_delete_search failed");
        end
        $finish;
    end

endmodule

// ----- ordered_array_insert_delete_search.f -----
src/oaids_pkg.sv
src/oaids_ram.sv
src/oaids_seq.sv
src/ordered_array_insert_delete_search.sv
sim/tb_ordered_array_insert_delete_search.sv
